/* sv/gct_pkg.sv */
package gct_pkg;

  // Default size of the vertex set.
  localparam int MAX_VERTICES_DEF = 16;

  // Fixed field widths.
  localparam int MODE_W     = 2;
  localparam int VERTEX_W   = 4;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Traversal kinds.
  localparam logic KIND_BFS = 1'b0;
  localparam logic KIND_DFS = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAVERSAL_KIND = 1'd1;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

endpackage

/* sv/gct_if.sv */
interface gct_req_if import gct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [VERTEX_W-1:0] edge_from;
  logic [VERTEX_W-1:0] edge_to;

  modport source (output valid, output mode, output edge_from, output edge_to, input ready);
  modport sink   (input valid, input mode, input edge_from, input edge_to, output ready);
endinterface

interface gct_rsp_if import gct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] vertex;
  logic                component_start;
  logic                last;

  modport source (output valid, output vertex, output component_start, output last,
                  input ready);
  modport sink   (input valid, input vertex, input component_start, input last,
                  output ready);
endinterface

/* sv/gct_pick.sv */
module gct_pick import gct_pkg::*; #(
  parameter int WIDTH = MAX_VERTICES_DEF,
  parameter int IDX_W = $clog2(MAX_VERTICES_DEF)
) (
  input  logic [WIDTH-1:0] bits,
  output logic [IDX_W-1:0] idx,
  output logic             any
);

  // Lowest set bit wins: scan from the top so the lowest index is written last.
  always_comb begin
    idx = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = IDX_W'(i);
      end
    end
    any = |bits;
  end

endmodule

/* sv/graph_component_traversal_top.sv */
// An edge request inside the active range updates both of its rows through S_EDGE_A and
// S_EDGE_B; ignored edges, clear requests and unused modes finish in idle. A run picks
// each component root, then takes vertices from the breadth-first queue or depth-first
// stack through S_POP, S_VREAD and S_ROW (breadth-first adds S_EXPAND); S_FLUSH closes it.
// One request is in work at a time; the next is taken once the block is back in idle.
// Synchronous active-high reset clears the edge matrix, visited set and config.
module graph_component_traversal_top import gct_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gct_req_if.sink               request,
  gct_rsp_if.source             result
);

  // Vertex index width, stack/queue pointer width and count compare width.
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int PW = $clog2(MAX_VERTICES + 1);
  localparam int NW = (PW > COUNT_W) ? PW : COUNT_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EDGE_A = 4'd1;
  localparam logic [3:0] S_EDGE_B = 4'd2;
  localparam logic [3:0] S_ROOT   = 4'd3;
  localparam logic [3:0] S_POP    = 4'd4;
  localparam logic [3:0] S_VREAD  = 4'd5;
  localparam logic [3:0] S_ROW    = 4'd6;
  localparam logic [3:0] S_EXPAND = 4'd7;
  localparam logic [3:0] S_FLUSH  = 4'd8;

  localparam logic [MAX_VERTICES-1:0] ONE_BIT = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

  // Configuration registers.
  logic [COUNT_W-1:0] vertex_count;
  logic               traversal_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count   <= VERTEX_COUNT_RESET;
      traversal_kind <= KIND_BFS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTEX_COUNT:   vertex_count   <= cfg_data[COUNT_W-1:0];
        REG_TRAVERSAL_KIND: traversal_kind <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The vertex count in use is capped at the matrix size, and the mask keeps
  // every vertex at or above it out of the walk.
  logic [NW-1:0]           n_eff;
  logic [MAX_VERTICES-1:0] vmask;

  always_comb begin
    n_eff = (NW'(vertex_count) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vertex_count);
    for (int i = 0; i < MAX_VERTICES; i++) begin
      vmask[i] = (NW'(i) < n_eff);
    end
  end

  // Sequencer and datapath registers.
  logic [3:0]              state, state_next;
  logic [MAX_VERTICES-1:0] visited, visited_next;
  logic [MAX_VERTICES-1:0] cand, cand_next;
  logic [PW-1:0]           head, head_next;
  logic [PW-1:0]           tail, tail_next;
  logic [VW-1:0]           ea, ea_next;
  logic [VW-1:0]           eb, eb_next;
  logic [MAX_VERTICES-1:0] row_valid, row_valid_next;

  // Adjacency matrix: one row per vertex, one registered read port. A row whose
  // valid bit is clear reads as empty, so reset and clear requests take effect at once.
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic                    adj_we, adj_re;
  logic [VW-1:0]           adj_wa, adj_ra;
  logic [MAX_VERTICES-1:0] adj_wd, adj_q, row_data;
  logic                    adj_qv;

  // Queue for breadth-first, stack for depth-first; entries are always written
  // before they are read.
  logic [VW-1:0] pend_mem [MAX_VERTICES];
  logic          pend_we, pend_re;
  logic [VW-1:0] pend_wa, pend_wd, pend_ra, pend_q;

  // Shared lowest-bit picker.
  logic [MAX_VERTICES-1:0] pick_in;
  logic [VW-1:0]           pick_idx;
  logic                    pick_any;

  // The newest visited vertex waits in a hold register until the next one
  // arrives or the run ends, which is when its last flag is known.
  logic          hv;
  logic [VW-1:0] h_vert;
  logic          h_start;
  logic          emit, emit_start, flush_push, emit_ok, out_free;
  logic          req_fire;
  logic [PW-1:0] tail_m1;

  gct_pick #(
    .WIDTH (MAX_VERTICES),
    .IDX_W (VW)
  ) u_pick (
    .bits (pick_in),
    .idx  (pick_idx),
    .any  (pick_any)
  );

  assign request.ready = (state == S_IDLE);
  assign req_fire      = request.valid && request.ready;
  assign row_data      = adj_qv ? adj_q : '0;
  assign out_free      = !result.valid || result.ready;
  assign emit_ok       = !hv || out_free;
  assign tail_m1       = tail - 1'b1;

  always_comb begin
    case (state)
      S_ROOT:   pick_in = ~visited & vmask;
      S_EXPAND: pick_in = cand;
      default:  pick_in = row_data & vmask & ~visited;
    endcase
  end

  always_comb begin
    state_next     = state;
    visited_next   = visited;
    cand_next      = cand;
    head_next      = head;
    tail_next      = tail;
    ea_next        = ea;
    eb_next        = eb;
    row_valid_next = row_valid;
    adj_we         = 1'b0;
    adj_wa         = ea;
    adj_wd         = row_data | (ONE_BIT << eb);
    adj_re         = 1'b0;
    adj_ra         = ea;
    pend_we        = 1'b0;
    pend_wa        = tail[VW-1:0];
    pend_wd        = pick_idx;
    pend_re        = 1'b0;
    pend_ra        = head[VW-1:0];
    emit           = 1'b0;
    emit_start     = 1'b0;
    flush_push     = 1'b0;

    case (state)
      S_IDLE: begin
        if (req_fire) begin
          case (request.mode)
            MODE_EDGE: begin
              if ((NW'(request.edge_from) < n_eff) && (NW'(request.edge_to) < n_eff)) begin
                ea_next    = VW'(request.edge_from);
                eb_next    = VW'(request.edge_to);
                adj_re     = 1'b1;
                adj_ra     = VW'(request.edge_from);
                state_next = S_EDGE_A;
              end
            end
            MODE_RUN: begin
              visited_next = '0;
              state_next   = S_ROOT;
            end
            MODE_CLEAR: row_valid_next = '0;
            default: ;
          endcase
        end
      end

      // Read-modify-write of the first row, then the second.
      S_EDGE_A: begin
        adj_we             = 1'b1;
        row_valid_next[ea] = 1'b1;
        adj_re             = 1'b1;
        adj_ra             = eb;
        state_next         = S_EDGE_B;
      end

      S_EDGE_B: begin
        adj_we             = 1'b1;
        adj_wa             = eb;
        adj_wd             = row_data | (ONE_BIT << ea);
        row_valid_next[eb] = 1'b1;
        state_next         = S_IDLE;
      end

      // Lowest unvisited vertex opens the next component.
      S_ROOT: begin
        if (!pick_any) begin
          state_next = S_FLUSH;
        end else if (emit_ok) begin
          visited_next = visited | (ONE_BIT << pick_idx);
          emit         = 1'b1;
          emit_start   = 1'b1;
          pend_we      = 1'b1;
          pend_wa      = '0;
          head_next    = '0;
          tail_next    = PW'(1);
          state_next   = S_POP;
        end
      end

      S_POP: begin
        if (traversal_kind == KIND_BFS) begin
          if (head == tail) begin
            state_next = S_ROOT;
          end else begin
            pend_re    = 1'b1;
            head_next  = head + 1'b1;
            state_next = S_VREAD;
          end
        end else begin
          if (tail == '0) begin
            state_next = S_ROOT;
          end else begin
            pend_re    = 1'b1;
            pend_ra    = tail_m1[VW-1:0];
            state_next = S_VREAD;
          end
        end
      end

      S_VREAD: begin
        adj_re     = 1'b1;
        adj_ra     = pend_q;
        state_next = S_ROW;
      end

      S_ROW: begin
        if (traversal_kind == KIND_BFS) begin
          cand_next  = row_data & vmask & ~visited;
          state_next = S_EXPAND;
        end else if (!pick_any) begin
          tail_next  = tail_m1;
          state_next = S_POP;
        end else if (emit_ok) begin
          visited_next = visited | (ONE_BIT << pick_idx);
          emit         = 1'b1;
          if (tail < PW'(MAX_VERTICES)) begin
            pend_we   = 1'b1;
            tail_next = tail + 1'b1;
          end
          state_next = S_POP;
        end
      end

      // Breadth-first: every unvisited neighbor of the popped vertex in turn.
      S_EXPAND: begin
        if (!pick_any) begin
          state_next = S_POP;
        end else if (emit_ok) begin
          visited_next = visited | (ONE_BIT << pick_idx);
          cand_next    = cand & ~(ONE_BIT << pick_idx);
          emit         = 1'b1;
          if (tail < PW'(MAX_VERTICES)) begin
            pend_we   = 1'b1;
            tail_next = tail + 1'b1;
          end
        end
      end

      S_FLUSH: begin
        if (!hv) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          flush_push = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      visited   <= '0;
      head      <= '0;
      tail      <= '0;
      row_valid <= '0;
    end else begin
      state     <= state_next;
      visited   <= visited_next;
      head      <= head_next;
      tail      <= tail_next;
      row_valid <= row_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cand <= cand_next;
    ea   <= ea_next;
    eb   <= eb_next;
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    if (adj_re) begin
      adj_q  <= adj_mem[adj_ra];
      adj_qv <= row_valid[adj_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_wa] <= pend_wd;
    end
    if (pend_re) begin
      pend_q <= pend_mem[pend_ra];
    end
  end

  // Hold register and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hv           <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (emit) begin
        hv <= 1'b1;
      end else if (flush_push) begin
        hv <= 1'b0;
      end
      if ((emit && hv) || flush_push) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      h_vert  <= pick_idx;
      h_start <= emit_start;
    end
    if ((emit && hv) || flush_push) begin
      result.vertex          <= VERTEX_W'(h_vert);
      result.component_start <= h_start;
      result.last            <= flush_push;
    end
  end

  // A new request is only taken once the last vertex of a run has left the hold.
  a_idle_hold_empty: assert property (@(posedge clk) disable iff (rst)
    request.ready |-> !hv)
    else $error("hold register busy while accepting a request");

  // The breadth-first queue never reads past its write pointer.
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("queue head passed tail");

  // Neighbor candidates are never already visited.
  a_cand_unvisited: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXPAND) |-> ((cand & visited) == '0))
    else $error("candidate vertex already visited");

  // A vertex is only moved from hold to output when the output slot is free.
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    ((emit && hv) || flush_push) |-> out_free)
    else $error("result overwritten before it was taken");

endmodule

/* tb/tb_graph_component_traversal_top.sv */
module tb_graph_component_traversal_top;
  import gct_pkg::*;

  // Mode 3 has no meaning; the block must swallow it without a result.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int NV              = MAX_VERTICES_DEF;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 41;
  // A run still passes S_ROOT and S_FLUSH after its final vertex, and an edge request
  // passes S_EDGE_A and S_EDGE_B without emitting anything, so settle well past both.
  localparam int SETTLE_CYCLES   = 40;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int LONG_HOLD       = 400;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                component_start;
    logic                last;
  } visit_t;

  typedef enum logic {ROW_CONFIG, ROW_REQUEST} row_kind_t;

  // One line of the directed table. A request row either carries its visit
  // sequence typed in (nibble i is the vertex of visit i, bit i of the start mask
  // flags a component start) or leaves the expectation to the predictor.
  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [MODE_W-1:0]     mode;
    logic [VERTEX_W-1:0]   from_v;
    logic [VERTEX_W-1:0]   to_v;
    bit                    known;
    int                    known_cnt;
    logic [15:0]           known_vtx;
    logic [3:0]            known_start;
  } directed_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gct_req_if req_ch ();
  gct_rsp_if rsp_ch ();

  graph_component_traversal_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (req_ch),
    .result    (rsp_ch)
  );

  // Predictor state: the adjacency matrix and the two registers as the block
  // should hold them.
  logic [NV-1:0]      adj_rows [NV];
  logic [COUNT_W-1:0] cur_vertex_count;
  logic               cur_kind;

  // Visits still owed by the block, oldest first.
  visit_t expected_visits [$];
  visit_t head_visit;

  directed_row_t directed_rows [$];

  int fail_count;
  int requests_sent;
  int runs_sent;
  int visits_checked;
  int reg_writes;
  int burst_left;
  bit long_hold_pending;

  always #5 clk = ~clk;

  // Every input gets a known value at time zero; reset starts high and is released
  // on a falling edge.
  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.mode       = MODE_EDGE;
    req_ch.edge_from  = '0;
    req_ch.edge_to    = '0;
    rsp_ch.ready      = 1'b0;
    long_hold_pending = 1'b0;
  end

  // Safety net: the slowest correct run is far below this.
  initial begin
    #10_000_000;
    $display("tb_graph_component_traversal_top NOT OK");
    $finish;
  end

  // Breadth-first or depth-first walk over the whole graph, or an update of the
  // matrix, depending on the request mode. Runs push their visits onto the
  // expectation queue, with the last flag on the final visit.
  task automatic predict_visits(input logic [MODE_W-1:0] m, input logic [VERTEX_W-1:0] a,
                                input logic [VERTEX_W-1:0] b);
    int          n;
    int          head;
    int          tail;
    int          v;
    int          w;
    int          pend [NV];
    logic [NV-1:0] vmask;
    logic [NV-1:0] seen;
    logic [NV-1:0] cand;
    visit_t      run_q [$];
    visit_t      one;
    n     = (cur_vertex_count > NV) ? NV : int'(cur_vertex_count);
    vmask = (n >= NV) ? '1 : ((NV'(1) << n) - NV'(1));
    case (m)
      MODE_EDGE: begin
        // An edge naming a vertex outside the active range is dropped.
        if (int'(a) < n && int'(b) < n) begin
          adj_rows[a][b] = 1'b1;
          adj_rows[b][a] = 1'b1;
        end
      end
      MODE_CLEAR: begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
      end
      MODE_RUN: begin
        seen = '0;
        for (int root = 0; root < n; root++) begin
          if (!seen[root]) begin
            seen[root]          = 1'b1;
            one.vertex          = VERTEX_W'(root);
            one.component_start = 1'b1;
            one.last            = 1'b0;
            run_q.push_back(one);
            head    = 0;
            pend[0] = root;
            tail    = 1;
            if (cur_kind == KIND_BFS) begin
              while (head != tail) begin
                v    = pend[head];
                head = head + 1;
                cand = adj_rows[v] & vmask & ~seen;
                for (w = 0; w < NV; w++) begin
                  if (cand[w]) begin
                    seen[w]             = 1'b1;
                    one.vertex          = VERTEX_W'(w);
                    one.component_start = 1'b0;
                    run_q.push_back(one);
                    if (tail < NV) begin
                      pend[tail] = w;
                      tail       = tail + 1;
                    end
                  end
                end
              end
            end else begin
              // Top of the stack is the newest entry; a vertex is popped only
              // once it has no unvisited neighbor left.
              while (tail != 0) begin
                v    = pend[tail-1];
                cand = adj_rows[v] & vmask & ~seen;
                if (cand == '0) begin
                  tail = tail - 1;
                end else begin
                  w = 0;
                  while (!cand[w]) w++;
                  seen[w]             = 1'b1;
                  one.vertex          = VERTEX_W'(w);
                  one.component_start = 1'b0;
                  run_q.push_back(one);
                  if (tail < NV) begin
                    pend[tail] = w;
                    tail       = tail + 1;
                  end
                end
              end
            end
          end
        end
        if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
        foreach (run_q[i]) expected_visits.push_back(run_q[i]);
      end
      default: ;
    endcase
  endtask

  // One register write, driven on a falling edge and held for one clock.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_VERTEX_COUNT) cur_vertex_count = val;
    else cur_kind = val[0];
    reg_writes++;
  endtask

  // Offers one request and returns in the time step of the rising edge that took
  // it. The sender works in bursts: when a burst runs out, valid drops for a random
  // gap (sometimes none) before the next burst starts. Valid stays high between
  // requests of the same burst, so only the payload changes on those edges.
  task automatic send_request(input logic [MODE_W-1:0] m, input logic [VERTEX_W-1:0] a,
                              input logic [VERTEX_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap        = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        req_ch.valid     = 1'b0;
        req_ch.mode      = MODE_UNUSED;
        req_ch.edge_from = 4'($urandom);
        req_ch.edge_to   = 4'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    req_ch.valid     = 1'b1;
    req_ch.mode      = m;
    req_ch.edge_from = a;
    req_ch.edge_to   = b;
    do @(posedge clk); while (!req_ch.ready);
    burst_left--;
    requests_sent++;
    if (m == MODE_RUN) runs_sent++;
  endtask

  // Brings the block to rest: stop offering, wait for every owed visit, then let
  // the latency of a trailing edge request or an empty run pass.
  task automatic drain_results();
    int waited;
    @(negedge clk);
    req_ch.valid = 1'b0;
    burst_left   = 0;
    waited       = 0;
    while (expected_visits.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_visits.size() != 0) begin
      $display("%0t: %0d expected visits never arrived", $time, expected_visits.size());
      fail_count++;
      expected_visits.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    directed_row_t r;
    r.kind        = ROW_CONFIG;
    r.reg_idx     = idx;
    r.reg_val     = val;
    r.mode        = MODE_EDGE;
    r.from_v      = '0;
    r.to_v        = '0;
    r.known       = 1'b0;
    r.known_cnt   = 0;
    r.known_vtx   = '0;
    r.known_start = '0;
    directed_rows.push_back(r);
  endtask

  task automatic add_req(input logic [MODE_W-1:0] m, input logic [VERTEX_W-1:0] a = '0,
                         input logic [VERTEX_W-1:0] b = '0, input int cnt = -1,
                         input logic [15:0] vtx = '0, input logic [3:0] starts = '0);
    directed_row_t r;
    r.kind        = ROW_REQUEST;
    r.reg_idx     = REG_VERTEX_COUNT;
    r.reg_val     = '0;
    r.mode        = m;
    r.from_v      = a;
    r.to_v        = b;
    r.known       = (cnt >= 0);
    r.known_cnt   = cnt;
    r.known_vtx   = vtx;
    r.known_start = starts;
    directed_rows.push_back(r);
  endtask

  // Result checker: every visit the block hands over is matched against the
  // oldest expectation, field by field.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_visits.size() == 0) begin
        $display("%0t: unexpected visit: vertex %0d start %0b last %0b", $time,
                 rsp_ch.vertex, rsp_ch.component_start, rsp_ch.last);
        fail_count++;
      end else begin
        head_visit = expected_visits.pop_front();
        visits_checked++;
        if (rsp_ch.vertex !== head_visit.vertex) begin
          $display("%0t: vertex mismatch: expected %0d, actual %0d", $time,
                   head_visit.vertex, rsp_ch.vertex);
          fail_count++;
        end
        if (rsp_ch.component_start !== head_visit.component_start) begin
          $display("%0t: component_start mismatch: expected %0b, actual %0b", $time,
                   head_visit.component_start, rsp_ch.component_start);
          fail_count++;
        end
        if (rsp_ch.last !== head_visit.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b", $time,
                   head_visit.last, rsp_ch.last);
          fail_count++;
        end
      end
    end
  end

  // Receiver. It switches between stall styles after a random stretch: always
  // ready, coin flip, a repeating pattern from a tick counter, and mostly stalled. When the stimulus
  // asks for it, it holds ready low for a long stretch of its own counting, so the
  // block backs up and stops taking requests while the sender keeps offering.
  initial begin : receiver
    int style;
    int style_left;
    int tick;
    style      = 0;
    style_left = 0;
    tick       = 0;
    forever begin
      @(negedge clk);
      if (long_hold_pending) begin
        rsp_ch.ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold_pending = 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 3);
          style_left = $urandom_range(16, 96);
        end
        style_left--;
        tick++;
        case (style)
          0:       rsp_ch.ready = 1'b1;
          1:       rsp_ch.ready = 1'($urandom_range(0, 1));
          2:       rsp_ch.ready = ((tick % 4) != 0);
          default: rsp_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int          eff;
    int          pick;
    logic [MODE_W-1:0]   m;
    logic [VERTEX_W-1:0] a;
    logic [VERTEX_W-1:0] b;
    logic [COUNT_W-1:0]  vc;
    visit_t      one;

    fail_count       = 0;
    requests_sent    = 0;
    runs_sent        = 0;
    visits_checked   = 0;
    reg_writes       = 0;
    burst_left       = 0;
    cur_vertex_count = VERTEX_COUNT_RESET;
    cur_kind         = KIND_BFS;
    foreach (adj_rows[i]) adj_rows[i] = '0;

    // Directed table. Right after reset the graph has no edges, so the first run
    // walks sixteen one-vertex components.
    add_req(MODE_RUN);
    // Three vertices, one edge 0-2: breadth-first gives 0, 2, then 1 on its own.
    add_reg(REG_VERTEX_COUNT, 5'd3);
    add_req(MODE_EDGE, 4'd0, 4'd2);
    add_req(MODE_RUN, '0, '0, 3, 16'h0120, 4'b0101);
    // Edges reaching past the active range are dropped, a self loop changes
    // nothing in the walk, and the unused mode is ignored, so the order holds.
    add_req(MODE_EDGE, 4'd2, 4'd15);
    add_req(MODE_EDGE, 4'd15, 4'd0);
    add_req(MODE_EDGE, 4'd1, 4'd1);
    add_req(MODE_UNUSED, 4'd1, 4'd2);
    add_req(MODE_RUN, '0, '0, 3, 16'h0120, 4'b0101);
    // Full vertex set with edges that reach the highest index.
    add_reg(REG_VERTEX_COUNT, 5'd16);
    add_req(MODE_EDGE, 4'd0, 4'd15);
    add_req(MODE_EDGE, 4'd15, 4'd3);
    add_req(MODE_EDGE, 4'd0, 4'd7);
    add_req(MODE_EDGE, 4'd7, 4'd3);
    add_req(MODE_EDGE, 4'd3, 4'd9);
    add_req(MODE_EDGE, 4'd9, 4'd12);
    add_req(MODE_RUN);
    add_reg(REG_TRAVERSAL_KIND, {{(CFG_DATA_W-1){1'b0}}, KIND_DFS});
    add_req(MODE_RUN);
    // Shrinking the count masks off the stored edges to high vertices.
    add_reg(REG_VERTEX_COUNT, 5'd4);
    add_req(MODE_RUN);
    // No vertices at all: the run emits nothing.
    add_reg(REG_VERTEX_COUNT, 5'd0);
    add_req(MODE_RUN);
    // A count above the maximum is capped.
    add_reg(REG_VERTEX_COUNT, 5'd31);
    add_req(MODE_RUN);
    add_req(MODE_CLEAR);
    add_req(MODE_RUN);
    // A single vertex: one visit, starting a component and closing the run.
    add_reg(REG_VERTEX_COUNT, 5'd1);
    add_req(MODE_RUN, '0, '0, 1, 16'h0000, 4'b0001);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        drain_results();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_request(directed_rows[i].mode, directed_rows[i].from_v, directed_rows[i].to_v);
        if (directed_rows[i].known) begin
          for (int k = 0; k < directed_rows[i].known_cnt; k++) begin
            one.vertex          = directed_rows[i].known_vtx[4*k +: 4];
            one.component_start = directed_rows[i].known_start[k];
            one.last            = (k == directed_rows[i].known_cnt - 1);
            expected_visits.push_back(one);
          end
        end else begin
          predict_visits(directed_rows[i].mode, directed_rows[i].from_v,
                         directed_rows[i].to_v);
        end
      end
    end

    // Random phases. Each one starts from an idle block with a fresh setting; the
    // early ones cover small, full and capped counts and both walk orders. Most
    // requests are edges inside the active range, so components grow and merge
    // between runs; the rest are runs, clears, out-of-range edges and the unused mode.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0, 2:    vc = 5'd16;
        1:       vc = 5'd1;
        3:       vc = 5'd8;
        4:       vc = 5'd2;
        5:       vc = 5'd31;
        default: vc = 5'($urandom_range(3, 15));
      endcase
      write_reg(REG_VERTEX_COUNT, vc);
      write_reg(REG_TRAVERSAL_KIND,
                {{(CFG_DATA_W-1){1'b0}}, (phase < 2) ? KIND_BFS :
                 (phase == 2) ? KIND_DFS : 1'($urandom_range(0, 1))});
      // Start with a clean graph most of the time, keep the old one otherwise.
      if ($urandom_range(0, 3) != 0) begin
        send_request(MODE_CLEAR, '0, '0);
        predict_visits(MODE_CLEAR, '0, '0);
      end
      // One phase runs into a long receiver hold-off while requests keep coming.
      if (phase == 3) long_hold_pending = 1'b1;
      eff = (vc > NV) ? NV : int'(vc);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 99);
        a    = 4'($urandom);
        b    = 4'($urandom);
        if (pick < 3) begin
          m = MODE_UNUSED;
        end else if (pick < 6) begin
          m = MODE_CLEAR;
        end else if (pick < 20) begin
          m = MODE_RUN;
        end else begin
          m = MODE_EDGE;
          if (eff > 0 && $urandom_range(0, 9) != 0) begin
            a = 4'($urandom_range(0, eff - 1));
            b = 4'($urandom_range(0, eff - 1));
          end
        end
        send_request(m, a, b);
        predict_visits(m, a, b);
      end
      // Close every phase with a run so the final graph is always walked.
      send_request(MODE_RUN, '0, '0);
      predict_visits(MODE_RUN, '0, '0);
    end

    drain_results();

    $display("Covered %0d requests including %0d runs, %0d visits checked, %0d register writes,",
             requests_sent, runs_sent, visits_checked, reg_writes);
    $display("both walk orders, counts from zero to capped, and a long result back-pressure.");
    if (fail_count == 0) begin
      $display("tb_graph_component_traversal_top OK");
    end else begin
      $display("tb_graph_component_traversal_top NOT OK");
    end
    $finish;
  end

endmodule
